/* src/deq_pkg.sv */
// Shared word width, command and status codes, and the write request type
// for the double-ended queue. No dependencies.
package deq_pkg;

	localparam int WORD_W        = 32;
	localparam int CMD_W         = 3;
	localparam int STATUS_W      = 2;
	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic              wr_en;
		logic [WORD_W-1:0] wr_data;
	} deq_wr_t;

endpackage

/* src/deq_cell.sv */
// One storage cell of the rotating ring: takes its neighbor's word each cycle
// or a new word when written. Depends on deq_pkg.
module deq_cell import deq_pkg::*; (
	input  logic              clk,
	input  logic [WORD_W-1:0] shift_in,
	input  deq_wr_t           wr,
	output logic [WORD_W-1:0] data
);

	logic [WORD_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			data_q <= wr.wr_data;
		end else begin
			data_q <= shift_in;
		end
	end

	assign data = data_q;

endmodule

/* src/deq_ring.sv */
// Closed chain of deq_cell instances that rotates by one slot every cycle,
// with a slot counter that names the entry seen at the tap. Depends on deq_pkg.
module deq_ring import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  deq_wr_t                    wr,
	output logic [WORD_W-1:0]          tap_data,
	output logic [$clog2(DEPTH)-1:0]   tap_slot
);

	localparam int IW = $clog2(DEPTH);

	logic [WORD_W-1:0] cell_data [DEPTH];
	logic [IW-1:0]     rot_q;

	// Cell i holds slot (rot_q + i) mod DEPTH, so cell 0 is the tap. The word
	// leaving the tap re-enters at the far end, where writes land as well.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] nb_data;
		deq_wr_t           cell_wr;

		if (i == DEPTH - 1) begin : g_last
			assign nb_data = cell_data[0];
			assign cell_wr = wr;
		end else begin : g_mid
			assign nb_data = cell_data[i+1];
			assign cell_wr = '0;
		end

		deq_cell u_cell (
			.clk      (clk),
			.shift_in (nb_data),
			.wr       (cell_wr),
			.data     (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
		end else if (rot_q == IW'(DEPTH - 1)) begin
			rot_q <= '0;
		end else begin
			rot_q <= rot_q + 1'b1;
		end
	end

	assign tap_data = cell_data[0];
	assign tap_slot = rot_q;

endmodule

/* src/double_ended_queue.sv */
// Top level of the bounded double-ended queue: command decode, ring pointers,
// access sequencing and the result register. Depends on deq_pkg, deq_ring.
//
// The deque holds up to DEPTH signed 32-bit words and answers every command
// beat with exactly one result beat carrying the word read, a status, an
// empty flag and the count left after the command. The words live in a ring
// of DEPTH cells that rotates by one position every clock, so each slot of
// the ring buffer passes the single tap cell in turn; a command
// that touches an entry waits there until its slot comes round. A command
// that touches no entry (push when full, pop or peek when empty, unused
// code) goes from acceptance straight to the done state; a push, pop or
// peek first waits in the seek state for its slot to reach the tap. The
// result sits in an output register, so the next command is taken while a
// result still waits to be taken; only a second finished result stalls
// behind an untaken one. Entries hold no reset value, and the count
// guarantees no unwritten entry is ever read.
module double_ended_queue import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [CMD_W-1:0]             command,
	input  logic signed [WORD_W-1:0]     push_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [WORD_W-1:0]     read_value,
	output logic [STATUS_W-1:0]          status,
	output logic                         is_empty,
	output logic [$clog2(DEPTH+1)-1:0]   fill_count
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SEEK = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// Ring positions wrap once at most, since every sum stays below 2*DEPTH.
	function automatic logic [IW-1:0] wrap_slot(input logic [IW:0] pos);
		if (pos >= (IW+1)'(DEPTH)) begin
			return IW'(pos - (IW+1)'(DEPTH));
		end
		return pos[IW-1:0];
	endfunction

	state_t            state_q;
	logic [IW-1:0]     front_q;
	logic [CW-1:0]     count_q;

	// Command under way.
	logic [IW-1:0]     slot_q;
	logic              write_q;
	logic [WORD_W-1:0] wdata_q;
	status_t           res_status_q;
	logic [CW-1:0]     res_count_q;
	logic [WORD_W-1:0] rdata_q;

	// Output register.
	logic              out_valid_q;
	logic [WORD_W-1:0] out_value_q;
	status_t           out_status_q;
	logic              out_empty_q;
	logic [CW-1:0]     out_count_q;

	cmd_t              cmd;
	logic              accept;
	logic              out_free;
	logic              at_slot;
	logic [IW:0]       front_ext;
	logic [IW:0]       count_ext;
	logic [IW-1:0]     front_dec;
	logic [IW-1:0]     front_inc;
	logic [IW-1:0]     back_next;
	logic [IW-1:0]     back_slot;
	logic              is_full;
	logic              acc_access;
	logic              acc_write;
	logic [IW-1:0]     acc_slot;
	logic [IW-1:0]     nxt_front;
	logic [CW-1:0]     nxt_count;
	status_t           acc_status;

	deq_wr_t           ring_wr;
	logic [WORD_W-1:0] tap_data;
	logic [IW-1:0]     tap_slot;

	assign cmd      = cmd_t'(command);
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign at_slot  = (state_q == ST_SEEK) && (tap_slot == slot_q);

	// Neighbor slots of the two ends. The back sums are only used when the
	// count makes them meaningful.
	assign front_ext = {1'b0, front_q};
	assign count_ext = (IW+1)'(count_q);
	assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = wrap_slot(front_ext + 1'b1);
	assign back_next = wrap_slot(front_ext + count_ext);
	assign back_slot = wrap_slot(front_ext + count_ext - 1'b1);
	assign is_full   = (count_q == CW'(DEPTH));

	// Decode: everything but the word read is known at acceptance, so the
	// pointers move right away and only the entry access is deferred.
	always_comb begin
		acc_access = 1'b0;
		acc_write  = 1'b0;
		acc_slot   = front_q;
		nxt_front  = front_q;
		nxt_count  = count_q;
		acc_status = STAT_OK;
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (is_full) begin
					acc_status = STAT_FULL;
				end else begin
					acc_access = 1'b1;
					acc_write  = 1'b1;
					nxt_count  = count_q + 1'b1;
					if (cmd == CMD_PUSH_FRONT) begin
						acc_slot  = front_dec;
						nxt_front = front_dec;
					end else begin
						acc_slot = back_next;
					end
				end
			end
			CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
				if (count_q == '0) begin
					acc_status = STAT_EMPTY;
				end else begin
					acc_access = 1'b1;
					if (cmd == CMD_POP_FRONT || cmd == CMD_PEEK_FRONT) begin
						acc_slot = front_q;
					end else begin
						acc_slot = back_slot;
					end
					if (cmd == CMD_POP_FRONT) begin
						nxt_front = front_inc;
						nxt_count = count_q - 1'b1;
					end else if (cmd == CMD_POP_BACK) begin
						nxt_count = count_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Writes land at the far end of the ring in the cycle the target slot is
	// at the tap, which is exactly where that slot goes next.
	assign ring_wr.wr_en   = at_slot && write_q;
	assign ring_wr.wr_data = wdata_q;

	deq_ring #(
		.DEPTH (DEPTH)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (ring_wr),
		.tap_data (tap_data),
		.tap_slot (tap_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A finished result refills the output register; otherwise a
			// taken beat empties it.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						front_q <= nxt_front;
						count_q <= nxt_count;
						state_q <= acc_access ? ST_SEEK : ST_DONE;
					end
				end
				ST_SEEK: begin
					if (at_slot) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command and result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			slot_q       <= acc_slot;
			write_q      <= acc_write;
			wdata_q      <= push_value;
			res_status_q <= acc_status;
			res_count_q  <= nxt_count;
			rdata_q      <= '0;
		end else if (at_slot && !write_q) begin
			rdata_q <= tap_data;
		end
		if (state_q == ST_DONE && out_free) begin
			out_value_q  <= rdata_q;
			out_status_q <= res_status_q;
			out_empty_q  <= (res_count_q == '0);
			out_count_q  <= res_count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_value_q;
	assign status     = out_status_q;
	assign is_empty   = out_empty_q;
	assign fill_count = out_count_q;

`ifndef SYNTHESIS
	// An accepted command always occupies the sequencer for the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("command accepted but sequencer idle");

	// A taken result leaves the output empty unless a new one is being finished.
	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && state_q != ST_DONE) |=> !out_valid)
		else $error("result beat repeated");

	// A full report goes with a full count, an empty flag with a zero count.
	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status != STAT_FULL || fill_count == CW'(DEPTH)) &&
			(is_empty == (fill_count == '0))))
		else $error("status and count disagree");
`endif

endmodule
